FILE: src/gtph_pkg.sv
`timescale 1ns / 1ps

package gtph_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_PARSE_ERROR = 2'd1,
		STATUS_TRUNCATED   = 2'd2
	} status_t;

	// One packet byte with its framing marks.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        start_of_packet;
		logic        end_of_packet;
		logic [15:0] wire_length;
	} in_item_t;

	// One decoded header.
	typedef struct packed {
		status_t     status;
		logic [2:0]  version;
		logic [7:0]  message_type;
		logic [31:0] tunnel_id;
		logic        has_sequence;
		logic [15:0] sequence_number;
		logic        has_npdu;
		logic [7:0]  npdu_num;
		logic [15:0] header_length;
		logic [15:0] payload_length;
		logic        is_user_data;
		logic        length_mismatch;
	} result_t;

	// Byte offsets inside the GTP header.
	localparam logic [15:0] OFS_FLAGS       = 16'd0;
	localparam logic [15:0] OFS_MSG_TYPE    = 16'd1;
	localparam logic [15:0] OFS_LENGTH_LAST = 16'd3;
	localparam logic [15:0] OFS_TEID_LAST   = 16'd7;
	localparam logic [15:0] OFS_OPT_FIRST   = 16'd8;
	localparam logic [15:0] OFS_SEQ_LAST    = 16'd9;
	localparam logic [15:0] OFS_NPDU        = 16'd10;
	localparam logic [15:0] OFS_NEXT_EXT    = 16'd11;

	localparam logic [15:0] BASE_HEADER_LEN = 16'd8;
	localparam logic [15:0] MIN_WIRE_LENGTH = 16'd8;
	localparam logic [15:0] OFFSET_MAX      = 16'hFFFF;

	// Bit positions in the flags byte.
	localparam int FLAG_PT = 4;
	localparam int FLAG_E  = 2;
	localparam int FLAG_S  = 1;
	localparam int FLAG_PN = 0;

	localparam logic [2:0] VER_GTP1 = 3'd1;
	localparam logic [2:0] VER_GTP2 = 3'd2;
	localparam logic [7:0] MSG_GPDU = 8'hFF;

endpackage

FILE: src/gtph_in_if.sv
`timescale 1ns / 1ps

interface gtph_in_if;
	import gtph_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/gtph_out_if.sv
`timescale 1ns / 1ps

interface gtph_out_if;
	import gtph_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/gtp_header_parser.sv
`timescale 1ns / 1ps

// GTP header parser. Packet bytes enter on rx, one byte per transaction, and the
// block accepts a new byte in every cycle except while rx stalls. A byte is
// captured in an input register and parsed against the running header state in
// the following cycle; the result for the byte that completes the header, fails
// it, or ends the packet early is written to the result register and appears on
// tx from there. The result register holds one result, so rx stalls only while a
// byte that would produce a new result waits for tx to take the previous one.
// Bytes after a result are dropped until the next start of packet, and a start
// of packet in the middle of a header abandons that header without a result.
module gtp_header_parser (
	input  logic              clk,
	input  logic              arst_n,
	gtph_in_if.sink           rx,
	gtph_out_if.source        tx
);
	import gtph_pkg::*;

	// Input register.
	logic     valid_s1;
	in_item_t item_s1;

	// Result register.
	logic    res_valid_s2;
	result_t res_s2;

	// Header state.
	logic [15:0] byte_offset_q;
	logic [7:0]  header_flags_q;
	logic [7:0]  msg_type_q;
	logic [15:0] msg_length_q;
	logic [31:0] teid_q;
	logic [15:0] seq_q;
	logic [7:0]  npdu_q;
	logic [9:0]  ext_remaining_q;
	logic        ext_pending_q;
	logic        done_q;

	// Next state and result.
	logic [15:0] byte_offset_n;
	logic [7:0]  header_flags_n;
	logic [7:0]  msg_type_n;
	logic [15:0] msg_length_n;
	logic [31:0] teid_n;
	logic [15:0] seq_n;
	logic [7:0]  npdu_n;
	logic [9:0]  ext_remaining_n;
	logic        ext_pending_n;
	logic        done_n;

	logic        active;
	logic [15:0] cur;
	logic        fail;
	status_t     fail_status;
	logic        ok_v1;
	logic        ok_v2;
	logic        emit;
	logic        adv;
	logic [15:0] extra_len;
	logic [15:0] payload_len;
	logic [15:0] wire_rem;
	result_t     res;

	// Parse the registered byte against the header state.
	always_comb begin
		byte_offset_n   = byte_offset_q;
		header_flags_n  = header_flags_q;
		msg_type_n      = msg_type_q;
		msg_length_n    = msg_length_q;
		teid_n          = teid_q;
		seq_n           = seq_q;
		npdu_n          = npdu_q;
		ext_remaining_n = ext_remaining_q;
		ext_pending_n   = item_s1.start_of_packet ? 1'b0 : ext_pending_q;
		done_n          = done_q;
		fail            = 1'b0;
		fail_status     = STATUS_PARSE_ERROR;
		ok_v1           = 1'b0;
		ok_v2           = 1'b0;

		active = valid_s1 && (item_s1.start_of_packet || !done_q);
		cur    = item_s1.start_of_packet ? OFS_FLAGS : byte_offset_q;

		if (active) begin
			byte_offset_n = (cur == OFFSET_MAX) ? OFFSET_MAX : cur + 16'd1;
			done_n        = 1'b0;

			// Fixed header fields.
			if (cur == OFS_FLAGS) begin
				header_flags_n = item_s1.data_byte;
				if (item_s1.wire_length < MIN_WIRE_LENGTH) begin
					fail = 1'b1;
				end
			end else if (cur == OFS_MSG_TYPE) begin
				msg_type_n = item_s1.data_byte;
			end else if (cur <= OFS_LENGTH_LAST) begin
				msg_length_n = {msg_length_q[7:0], item_s1.data_byte};
			end else if (cur <= OFS_TEID_LAST) begin
				teid_n = {teid_q[23:0], item_s1.data_byte};
			end

			// Version check, optional bytes and the extension chain.
			if (cur == OFS_TEID_LAST) begin
				if (header_flags_n[7:5] == VER_GTP2) begin
					ok_v2 = 1'b1;
				end else if (header_flags_n[7:5] != VER_GTP1 || !header_flags_n[FLAG_PT]) begin
					fail = 1'b1;
				end else if (header_flags_n[FLAG_E:FLAG_PN] == 3'b000) begin
					ok_v1 = 1'b1;
				end
			end else if (cur >= OFS_OPT_FIRST && cur <= OFS_NEXT_EXT) begin
				if (cur <= OFS_SEQ_LAST) begin
					if (header_flags_n[FLAG_S]) begin
						seq_n = {seq_q[7:0], item_s1.data_byte};
					end
				end else if (cur == OFS_NPDU) begin
					if (header_flags_n[FLAG_PN]) begin
						npdu_n = item_s1.data_byte;
					end
				end else if (header_flags_n[FLAG_E] && item_s1.data_byte != 8'd0) begin
					ext_pending_n = 1'b1;
				end else begin
					ok_v1 = 1'b1;
				end
			end else if (cur > OFS_NEXT_EXT) begin
				if (ext_pending_q) begin
					// Extension length byte, counted in units of four bytes.
					if (item_s1.data_byte == 8'd0) begin
						fail = 1'b1;
					end else begin
						ext_remaining_n = {item_s1.data_byte, 2'b00} - 10'd1;
						ext_pending_n   = 1'b0;
					end
				end else begin
					ext_remaining_n = ext_remaining_q - 10'd1;
					if (ext_remaining_n == 10'd0) begin
						if (item_s1.data_byte == 8'd0) begin
							ok_v1 = 1'b1;
						end else begin
							ext_pending_n = 1'b1;
						end
					end
				end
			end

			// The packet ended before the header was complete.
			if (!(fail || ok_v1 || ok_v2) && item_s1.end_of_packet) begin
				fail        = 1'b1;
				fail_status = STATUS_TRUNCATED;
			end

			if (fail || ok_v1 || ok_v2) begin
				done_n = 1'b1;
			end
		end

		emit = active && (fail || ok_v1 || ok_v2);
	end

	// Length arithmetic for a version 1 header.
	always_comb begin
		extra_len   = byte_offset_n - BASE_HEADER_LEN;
		payload_len = (msg_length_n > extra_len) ? msg_length_n - extra_len : 16'd0;
		wire_rem    = (item_s1.wire_length > byte_offset_n) ?
			item_s1.wire_length - byte_offset_n : 16'd0;
	end

	// Result assembly.
	always_comb begin
		res         = '0;
		res.status  = STATUS_OK;
		res.version = header_flags_n[7:5];
		if (fail) begin
			res.status = fail_status;
		end else if (ok_v1) begin
			res.message_type    = msg_type_n;
			res.tunnel_id       = teid_n;
			res.has_sequence    = header_flags_n[FLAG_S];
			res.sequence_number = header_flags_n[FLAG_S] ? seq_n : 16'd0;
			res.has_npdu        = header_flags_n[FLAG_PN];
			res.npdu_num        = header_flags_n[FLAG_PN] ? npdu_n : 8'd0;
			res.header_length   = byte_offset_n;
			res.payload_length  = payload_len;
			res.is_user_data    = (msg_type_n == MSG_GPDU);
			res.length_mismatch = (msg_type_n == MSG_GPDU) && (payload_len != wire_rem);
		end
	end

	// Advance unless a new result would overwrite one that tx has not taken.
	assign adv      = valid_s1 && (!emit || !res_valid_s2 || tx.ready);
	assign rx.ready = !valid_s1 || adv;
	assign tx.valid = res_valid_s2;
	assign tx.data  = res_s2;

	// Control and header state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			res_valid_s2    <= 1'b0;
			byte_offset_q   <= '0;
			header_flags_q  <= '0;
			msg_type_q      <= '0;
			msg_length_q    <= '0;
			teid_q          <= '0;
			seq_q           <= '0;
			npdu_q          <= '0;
			ext_remaining_q <= '0;
			ext_pending_q   <= 1'b0;
			done_q          <= 1'b1;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (adv && emit) begin
				res_valid_s2 <= 1'b1;
			end else if (tx.ready) begin
				res_valid_s2 <= 1'b0;
			end
			if (adv) begin
				byte_offset_q   <= byte_offset_n;
				header_flags_q  <= header_flags_n;
				msg_type_q      <= msg_type_n;
				msg_length_q    <= msg_length_n;
				teid_q          <= teid_n;
				seq_q           <= seq_n;
				npdu_q          <= npdu_n;
				ext_remaining_q <= ext_remaining_n;
				ext_pending_q   <= ext_pending_n;
				done_q          <= done_n;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= rx.data;
		end
		if (adv && emit) begin
			res_s2 <= res;
		end
	end

endmodule

FILE: src/gtph_checker.sv
`timescale 1ns / 1ps

module gtph_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              tx_valid,
	input logic              tx_ready,
	input gtph_pkg::result_t tx_data
);
	import gtph_pkg::*;

	// A stalled result transaction keeps its contents.
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_data))
		else $error("result changed while stalled");

	// Failed headers carry only status and version.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_data.status != STATUS_OK |->
			tx_data.message_type == 8'd0 && tx_data.tunnel_id == 32'd0 &&
			tx_data.header_length == 16'd0 && tx_data.payload_length == 16'd0 &&
			!tx_data.has_sequence && !tx_data.has_npdu)
		else $error("failed result carries header fields");

	// A good header is either version 2 with empty fields or version 1 of at least 8 bytes.
	a_ok_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_data.status == STATUS_OK |->
			(tx_data.version == VER_GTP2 && tx_data.header_length == 16'd0) ||
			(tx_data.version == VER_GTP1 && tx_data.header_length >= BASE_HEADER_LEN))
		else $error("good result with bad version or header length");

	// Optional numbers appear only with their flags.
	a_opt_flags: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |->
			(tx_data.has_sequence || tx_data.sequence_number == 16'd0) &&
			(tx_data.has_npdu || tx_data.npdu_num == 8'd0))
		else $error("optional number without its flag");

	// A length mismatch is reported only for good G-PDU headers.
	a_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_data.length_mismatch |->
			tx_data.is_user_data && tx_data.status == STATUS_OK &&
			tx_data.message_type == MSG_GPDU)
		else $error("length mismatch outside a G-PDU");

endmodule

bind gtp_header_parser gtph_checker u_gtph_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.tx_valid (tx.valid),
	.tx_ready (tx.ready),
	.tx_data  (tx.data)
);

FILE: tb/sv/tb_gtp_header_parser.sv
`timescale 1ns / 1ps

module tb_gtp_header_parser;
	import gtph_pkg::*;

	localparam int RANDOM_BYTES_PER_PHASE = 250;
	localparam int DRAIN_LIMIT_CYCLES     = 5000;
	localparam int MAX_PRINTED_ERRORS     = 100;

	logic clk = 1'b0;
	logic arst_n;

	gtph_in_if  rx ();
	gtph_out_if tx ();

	gtp_header_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.tx(tx)
	);

	always #5 clk = ~clk;

	// Mirror of the header parsing state.
	logic [15:0] hdr_offset;
	logic [7:0]  hdr_flags;
	logic [7:0]  hdr_msg_type;
	logic [15:0] hdr_msg_len;
	logic [31:0] hdr_teid;
	logic [15:0] hdr_seq;
	logic [7:0]  hdr_npdu;
	logic [9:0]  ext_left;
	logic        ext_len_next;
	logic        awaiting_start;

	result_t     expected_headers[$];
	logic [7:0]  pkt_bytes[$];
	int unsigned error_count = 0;
	int unsigned parsed_bytes = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// Mismatch reporting.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < MAX_PRINTED_ERRORS)
			$display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	task automatic clear_header_state();
		hdr_offset = '0;
		hdr_flags = '0;
		hdr_msg_type = '0;
		hdr_msg_len = '0;
		hdr_teid = '0;
		hdr_seq = '0;
		hdr_npdu = '0;
		ext_left = '0;
		ext_len_next = 1'b0;
		awaiting_start = 1'b1;
	endtask

	function automatic result_t failed_header(input status_t st);
		result_t r;
		r = '0;
		r.status = st;
		r.version = hdr_flags[7:5];
		return r;
	endfunction

	// Complete version 1 header; cur is the offset of the byte that completes it.
	function automatic result_t decoded_header(input int unsigned cur, input logic [15:0] wl);
		result_t r;
		int unsigned hlen, extra, payload, remain;
		r = '0;
		hlen = cur + 1;
		if (hlen > OFFSET_MAX)
			hlen = OFFSET_MAX;
		extra = hlen - BASE_HEADER_LEN;
		payload = (hdr_msg_len > extra) ? hdr_msg_len - extra : 0;
		remain = (wl > hlen) ? wl - hlen : 0;
		r.status = STATUS_OK;
		r.version = hdr_flags[7:5];
		r.message_type = hdr_msg_type;
		r.tunnel_id = hdr_teid;
		r.has_sequence = hdr_flags[FLAG_S];
		r.sequence_number = hdr_flags[FLAG_S] ? hdr_seq : 16'd0;
		r.has_npdu = hdr_flags[FLAG_PN];
		r.npdu_num = hdr_flags[FLAG_PN] ? hdr_npdu : 8'd0;
		r.header_length = hlen[15:0];
		r.payload_length = payload[15:0];
		r.is_user_data = (hdr_msg_type == MSG_GPDU);
		r.length_mismatch = (hdr_msg_type == MSG_GPDU) && (payload != remain);
		return r;
	endfunction

	// Advance the parser mirror by one accepted byte.
	task automatic parse_header_byte(input in_item_t it, output bit ignored,
			output bit produced, output result_t r);
		int unsigned cur;
		logic [7:0] d;
		ignored = 1'b0;
		produced = 1'b0;
		r = '0;
		d = it.data_byte;
		if (it.start_of_packet) begin
			clear_header_state();
			awaiting_start = 1'b0;
			cur = 0;
		end else if (awaiting_start) begin
			ignored = 1'b1;
			return;
		end else begin
			cur = hdr_offset;
		end
		hdr_offset = (cur < OFFSET_MAX) ? 16'(cur + 1) : OFFSET_MAX;

		// Fixed header fields.
		if (cur == OFS_FLAGS) begin
			hdr_flags = d;
			if (it.wire_length < MIN_WIRE_LENGTH) begin
				produced = 1'b1;
				r = failed_header(STATUS_PARSE_ERROR);
			end
		end else if (cur == OFS_MSG_TYPE) begin
			hdr_msg_type = d;
		end else if (cur <= OFS_LENGTH_LAST) begin
			hdr_msg_len = {hdr_msg_len[7:0], d};
		end else if (cur <= OFS_TEID_LAST) begin
			hdr_teid = {hdr_teid[23:0], d};
		end

		// Version checks, optional bytes and the extension chain.
		if (!produced) begin
			if (cur == OFS_TEID_LAST) begin
				if (hdr_flags[7:5] == VER_GTP2) begin
					produced = 1'b1;
					r = '0;
					r.version = VER_GTP2;
				end else if (hdr_flags[7:5] != VER_GTP1 || !hdr_flags[FLAG_PT]) begin
					produced = 1'b1;
					r = failed_header(STATUS_PARSE_ERROR);
				end else if (hdr_flags[2:0] == 3'b000) begin
					produced = 1'b1;
					r = decoded_header(cur, it.wire_length);
				end
			end else if (cur >= OFS_OPT_FIRST && cur <= OFS_NEXT_EXT) begin
				if (cur <= OFS_SEQ_LAST) begin
					if (hdr_flags[FLAG_S])
						hdr_seq = {hdr_seq[7:0], d};
				end else if (cur == OFS_NPDU) begin
					if (hdr_flags[FLAG_PN])
						hdr_npdu = d;
				end else if (hdr_flags[FLAG_E] && d != 8'd0) begin
					ext_len_next = 1'b1;
				end else begin
					produced = 1'b1;
					r = decoded_header(cur, it.wire_length);
				end
			end else if (cur > OFS_NEXT_EXT) begin
				if (ext_len_next) begin
					if (d == 8'd0) begin
						produced = 1'b1;
						r = failed_header(STATUS_PARSE_ERROR);
					end else begin
						ext_left = {d, 2'b00} - 10'd1;
						ext_len_next = 1'b0;
					end
				end else begin
					ext_left = ext_left - 10'd1;
					if (ext_left == 10'd0) begin
						if (d == 8'd0) begin
							produced = 1'b1;
							r = decoded_header(cur, it.wire_length);
						end else begin
							ext_len_next = 1'b1;
						end
					end
				end
			end
		end

		if (!produced && it.end_of_packet) begin
			produced = 1'b1;
			r = failed_header(STATUS_TRUNCATED);
		end
		if (produced)
			awaiting_start = 1'b1;
	endtask

	// Send one byte transaction, idling at random first.
	task automatic send_byte(input logic [7:0] d, input bit sop, input bit eop,
			input logic [15:0] wl);
		in_item_t it;
		bit ignored;
		bit produced;
		result_t r;
		it.data_byte = d;
		it.start_of_packet = sop;
		it.end_of_packet = eop;
		it.wire_length = wl;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.data <= it;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		parse_header_byte(it, ignored, produced, r);
		if (produced)
			expected_headers.push_back(r);
		if (!ignored)
			parsed_bytes++;
	endtask

	// Send the buffered packet bytes and empty the buffer.
	task automatic send_packet(input logic [15:0] wl, input bit with_eop);
		int i;
		for (i = 0; i < pkt_bytes.size(); i++)
			send_byte(pkt_bytes[i], i == 0, with_eop && i == pkt_bytes.size() - 1, wl);
		pkt_bytes.delete();
	endtask

	task automatic keep_bytes(input int n);
		while (pkt_bytes.size() > n)
			void'(pkt_bytes.pop_back());
	endtask

	task automatic push_base(input logic [7:0] flags, input logic [7:0] mtype,
			input logic [15:0] mlen, input logic [31:0] teid);
		pkt_bytes.push_back(flags);
		pkt_bytes.push_back(mtype);
		pkt_bytes.push_back(mlen[15:8]);
		pkt_bytes.push_back(mlen[7:0]);
		pkt_bytes.push_back(teid[31:24]);
		pkt_bytes.push_back(teid[23:16]);
		pkt_bytes.push_back(teid[15:8]);
		pkt_bytes.push_back(teid[7:0]);
	endtask

	task automatic push_opt(input logic [15:0] seq, input logic [7:0] npdu,
			input logic [7:0] next_ext);
		pkt_bytes.push_back(seq[15:8]);
		pkt_bytes.push_back(seq[7:0]);
		pkt_bytes.push_back(npdu);
		pkt_bytes.push_back(next_ext);
	endtask

	// One extension header of len words: length byte, content, next type.
	task automatic push_ext(input int unsigned len, input logic [7:0] next_ext);
		pkt_bytes.push_back(8'(len));
		repeat (4 * len - 2)
			pkt_bytes.push_back(8'($urandom));
		pkt_bytes.push_back(next_ext);
	endtask

	// Mostly well-formed version 1 packets with random content, plus broken ones.
	task automatic build_random_packet(output logic [15:0] wl, output bit with_eop);
		logic [7:0] flags;
		logic [7:0] mtype;
		logic [15:0] mlen;
		int unsigned n_ext, e, hlen, pay, kind, pick, idx;
		kind = $urandom_range(99);
		flags = 8'($urandom);
		pick = $urandom_range(19);
		if (pick < 17)
			flags[7:5] = VER_GTP1;
		else if (pick == 17)
			flags[7:5] = VER_GTP2;
		if ($urandom_range(9) != 0)
			flags[FLAG_PT] = 1'b1;
		if ($urandom_range(3) == 0)
			flags[2:0] = 3'b000;
		mtype = ($urandom_range(1) != 0) ? MSG_GPDU : 8'($urandom);
		n_ext = flags[FLAG_E] ? $urandom_range(3) : 0;
		push_base(flags, mtype, 16'd0, $urandom);
		if (flags[2:0] != 3'b000) begin
			if (flags[FLAG_E])
				push_opt(16'($urandom), 8'($urandom),
						(n_ext != 0) ? 8'($urandom_range(255, 1)) : 8'd0);
			else
				push_opt(16'($urandom), 8'($urandom), 8'($urandom));
		end
		for (e = 0; e < n_ext; e++)
			push_ext(($urandom_range(7) == 0) ? $urandom_range(8, 1) : $urandom_range(2, 1),
					(e + 1 < n_ext) ? 8'($urandom_range(255, 1)) : 8'd0);
		hlen = pkt_bytes.size();

		// Message length and wire length, mostly consistent.
		pay = $urandom_range(40);
		mlen = ($urandom_range(3) != 0) ? 16'(hlen - 8 + pay) : 16'($urandom);
		pkt_bytes[2] = mlen[15:8];
		pkt_bytes[3] = mlen[7:0];
		pick = $urandom_range(9);
		if (pick < 6)
			wl = 16'(hlen + pay);
		else if (pick < 8)
			wl = 16'($urandom);
		else
			wl = 16'($urandom_range(hlen + pay));
		repeat ($urandom_range(3))
			pkt_bytes.push_back(8'($urandom));
		with_eop = 1'b1;

		// Damage some packets.
		if (kind < 60) begin
		end else if (kind < 72) begin
			keep_bytes($urandom_range(hlen - 1, 1));
		end else if (kind < 80) begin
			keep_bytes($urandom_range(hlen - 1, 1));
			with_eop = 1'b0;
		end else if (kind < 88) begin
			if (n_ext != 0)
				pkt_bytes[OFS_NEXT_EXT + 1] = 8'd0;
		end else begin
			idx = $urandom_range(hlen - 1);
			pkt_bytes[idx] = 8'($urandom);
			keep_bytes($urandom_range(pkt_bytes.size(), 1));
			with_eop = 1'($urandom_range(1));
		end
	endtask

	// Wire length checks and version decoding.
	task automatic test_length_and_version();
		pkt_bytes.push_back(8'h30);
		send_packet(16'd7, 1'b1);
		pkt_bytes.push_back(8'h00);
		send_packet(16'd0, 1'b1);
		push_base(8'h48, 8'h20, 16'h0010, 32'h1234_5678);
		send_packet(16'd100, 1'b1);
		push_base(8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_packet(16'hFFFF, 1'b1);
		push_base(8'h20, MSG_GPDU, 16'd0, 32'h0000_0001);
		send_packet(16'd8, 1'b1);
		push_base(8'h30, MSG_GPDU, 16'd0, 32'h0000_0000);
		send_packet(16'd8, 1'b1);
		push_base(8'h38, MSG_GPDU, 16'd4, 32'hDEAD_BEEF);
		send_packet(16'hFFFF, 1'b1);
	endtask

	// Sequence number, N-PDU number and the next-extension byte.
	task automatic test_optional_fields();
		push_base(8'h32, 8'h01, 16'd4, 32'h0000_0001);
		push_opt(16'hFFFF, 8'h00, 8'hFF);
		send_packet(16'd12, 1'b1);
		push_base(8'h31, MSG_GPDU, 16'd10, 32'h8000_0000);
		push_opt(16'h0000, 8'hFF, 8'h00);
		send_packet(16'd18, 1'b1);
		push_base(8'h34, MSG_GPDU, 16'd4, 32'h0102_0304);
		push_opt(16'hABCD, 8'h5A, 8'h00);
		send_packet(16'd12, 1'b1);
	endtask

	// Extension chains, including a zero extension length.
	task automatic test_extension_chain();
		push_base(8'h37, MSG_GPDU, 16'd16, 32'hCAFE_F00D);
		push_opt(16'h0102, 8'h03, 8'h85);
		push_ext(1, 8'hC0);
		push_ext(2, 8'h00);
		send_packet(16'd32, 1'b1);
		push_base(8'h34, 8'h10, 16'd8, 32'h0000_00FF);
		push_opt(16'h0000, 8'h00, 8'h85);
		pkt_bytes.push_back(8'h00);
		pkt_bytes.push_back(8'h77);
		send_packet(16'd40, 1'b1);
		push_base(8'h36, MSG_GPDU, 16'd8, 32'h0000_0002);
		push_opt(16'h4242, 8'h00, 8'h01);
		push_ext(1, 8'h01);
		pkt_bytes.push_back(8'h00);
		send_packet(16'd40, 1'b1);
	endtask

	// Early end, restart in the middle of a header and bytes outside packets.
	task automatic test_framing();
		push_base(8'h30, MSG_GPDU, 16'd0, 32'h0000_0003);
		keep_bytes(3);
		send_packet(16'd8, 1'b1);
		push_base(8'h34, MSG_GPDU, 16'd8, 32'h0000_0004);
		push_opt(16'h0000, 8'h00, 8'h85);
		push_ext(2, 8'h00);
		keep_bytes(15);
		send_packet(16'd20, 1'b1);
		push_base(8'h32, 8'h05, 16'd4, 32'h0000_0005);
		keep_bytes(5);
		send_packet(16'd12, 1'b0);
		push_base(8'h30, MSG_GPDU, 16'd0, 32'h0000_0006);
		send_packet(16'd8, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b1, 16'hFFFF);
		send_byte(8'h00, 1'b0, 1'b0, 16'h0000);
	endtask

	// A long extension whose length uses the upper bits of the extension counter.
	task automatic test_long_header();
		push_base(8'h34, MSG_GPDU, 16'hFFFF, 32'h5555_AAAA);
		push_opt(16'h0000, 8'h00, 8'h01);
		push_ext(64, 8'h00);
		send_packet(16'hFFFF, 1'b1);
	endtask

	// Random packets under one setting of source idling and result stalls.
	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned n_bytes);
		int unsigned target;
		logic [15:0] wl;
		bit with_eop;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = parsed_bytes + n_bytes;
		while (parsed_bytes < target) begin
			build_random_packet(wl, with_eop);
			send_packet(wl, with_eop);
			if ($urandom_range(6) == 0)
				send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)), 16'($urandom));
		end
	endtask

	task automatic compare_header(input result_t got, input result_t want);
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.version !== want.version)
			report_mismatch("version", 32'(got.version), 32'(want.version));
		if (got.message_type !== want.message_type)
			report_mismatch("message_type", 32'(got.message_type), 32'(want.message_type));
		if (got.tunnel_id !== want.tunnel_id)
			report_mismatch("tunnel_id", got.tunnel_id, want.tunnel_id);
		if (got.has_sequence !== want.has_sequence)
			report_mismatch("has_sequence", 32'(got.has_sequence), 32'(want.has_sequence));
		if (got.sequence_number !== want.sequence_number)
			report_mismatch("sequence_number", 32'(got.sequence_number),
					32'(want.sequence_number));
		if (got.has_npdu !== want.has_npdu)
			report_mismatch("has_npdu", 32'(got.has_npdu), 32'(want.has_npdu));
		if (got.npdu_num !== want.npdu_num)
			report_mismatch("npdu_num", 32'(got.npdu_num), 32'(want.npdu_num));
		if (got.header_length !== want.header_length)
			report_mismatch("header_length", 32'(got.header_length), 32'(want.header_length));
		if (got.payload_length !== want.payload_length)
			report_mismatch("payload_length", 32'(got.payload_length),
					32'(want.payload_length));
		if (got.is_user_data !== want.is_user_data)
			report_mismatch("is_user_data", 32'(got.is_user_data), 32'(want.is_user_data));
		if (got.length_mismatch !== want.length_mismatch)
			report_mismatch("length_mismatch", 32'(got.length_mismatch),
					32'(want.length_mismatch));
	endtask

	// Check every result transaction against the oldest expected header.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n === 1'b1 && tx.valid === 1'b1 && tx.ready === 1'b1) begin
			if (expected_headers.size() == 0) begin
				report_mismatch("unexpected result, status", 32'(tx.data.status), 32'd0);
			end else begin
				want = expected_headers.pop_front();
				compare_header(tx.data, want);
			end
		end
	end

	// Result side back pressure.
	initial begin : drive_result_ready
		tx.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tx.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Test sequence.
	initial begin : run_tests
		int wait_cycles;
		arst_n <= 1'b0;
		rx.valid <= 1'b0;
		rx.data <= '0;
		clear_header_state();
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_length_and_version();
		test_optional_fields();
		test_extension_chain();
		test_framing();
		test_long_header();
		test_random_traffic(0, 0, RANDOM_BYTES_PER_PHASE);
		test_random_traffic(67, 0, RANDOM_BYTES_PER_PHASE);
		test_random_traffic(0, 67, RANDOM_BYTES_PER_PHASE);
		test_random_traffic(38, 38, RANDOM_BYTES_PER_PHASE);
		rx.valid <= 1'b0;

		// Wait, up to the drain limit, for the outstanding results, then report the outcome.
		wait_cycles = 0;
		while (expected_headers.size() != 0 && wait_cycles < DRAIN_LIMIT_CYCLES) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (expected_headers.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_headers.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			repeat (10)
				@(posedge clk);
			if (error_count == 0)
				$display("Simulation PASSED");
			else
				$display("Simulation FAILED");
			$finish;
		end
	end

	// Overall time limit.
	initial begin : watchdog
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
